// ----- design/drop_oldest_queue_admission_unit_assert.svh -----
// Assertion macros for the drop-oldest queue admission unit
`ifndef DROP_OLDEST_QUEUE_ADMISSION_UNIT_ASSERT_SVH
`define DROP_OLDEST_QUEUE_ADMISSION_UNIT_ASSERT_SVH

// cond holds at every edge out of reset
`define DOQA_CHECK(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("doqa check failed");

// ante at one edge implies cons at the next
`define DOQA_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("doqa check failed");

`endif

// ----- design/doqa_pkg.sv -----
// Shared constants, types and state encoding for the admission queue
package doqa_pkg;

    localparam int DEPTH      = 64;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int TAIL_W     = CNT_W + 1;
    localparam int SIZE_W     = 32;
    localparam int BYTE_W     = SIZE_W + CNT_W;
    localparam int MSG_W      = 7;
    localparam int CMP_W      = (CNT_W > MSG_W) ? CNT_W : MSG_W;
    localparam int OUT_BYTE_W = 38;
    localparam int CFG_IDX_W  = 2;
    localparam int LAST_SLOT  = DEPTH - 1;

    localparam logic [CNT_W-1:0]  FULL_COUNT = DEPTH[CNT_W-1:0];
    localparam logic [TAIL_W-1:0] DEPTH_TAIL = DEPTH[TAIL_W-1:0];
    localparam logic [AW-1:0]     HEAD_LAST  = LAST_SLOT[AW-1:0];

    localparam logic [CFG_IDX_W-1:0] CFG_MSG_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 2'd1;

    localparam logic [MSG_W-1:0]  MSG_LIMIT_RST  = 7'd64;
    localparam logic [SIZE_W-1:0] BYTE_LIMIT_RST = 32'd1048576;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EVICT,
        S_BYPASS,
        S_POP_RD,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic op;
        logic bypass;
        logic need_room;
        logic empty;
        logic full;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic in_ready;
        logic unit_sub;
        logic append;
        logic remove;
        logic drop;
        logic evict;
        logic pop;
        logic load_out;
    } t_ctrl;

endpackage

// ----- design/doqa_store.sv -----
// Size store: one write port, one registered read port
module doqa_store (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [doqa_pkg::AW-1:0]        i_waddr,
    input  logic [doqa_pkg::SIZE_W-1:0]    i_wdata,
    input  logic [doqa_pkg::AW-1:0]        i_raddr,
    output logic [doqa_pkg::SIZE_W-1:0]    o_rdata
);

    logic [doqa_pkg::SIZE_W-1:0] r_mem [doqa_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/doqa_unit.sv -----
// Shared byte-total adder/subtractor with budget compare
module doqa_unit (
    input  logic [doqa_pkg::BYTE_W-1:0] i_acc,
    input  logic [doqa_pkg::SIZE_W-1:0] i_opnd,
    input  logic                        i_sub,
    input  logic [doqa_pkg::SIZE_W-1:0] i_limit,
    output logic [doqa_pkg::BYTE_W-1:0] o_result,
    output logic                        o_over
);

    logic [doqa_pkg::BYTE_W-1:0] w_opnd;

    assign w_opnd   = (doqa_pkg::BYTE_W)'(i_opnd);
    assign o_result = i_sub ? (i_acc - w_opnd) : (i_acc + w_opnd);
    assign o_over   = o_result > (doqa_pkg::BYTE_W)'(i_limit);

endmodule

// ----- design/doqa_ctrl.sv -----
// Sequencer for push, evict, bypass and pop steps
module doqa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  doqa_pkg::t_stat i_stat,
    output doqa_pkg::t_ctrl o_ctrl
);

    doqa_pkg::t_state r_state;
    doqa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= doqa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            doqa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.op == doqa_pkg::OP_POP) begin
                        n_state = doqa_pkg::S_POP_RD;
                    end else if (i_stat.bypass) begin
                        n_state = doqa_pkg::S_BYPASS;
                    end else begin
                        n_state = doqa_pkg::S_CHECK;
                    end
                end
            end
            doqa_pkg::S_CHECK: begin
                if (i_stat.need_room && !i_stat.empty) begin
                    n_state = doqa_pkg::S_EVICT;
                end else begin
                    n_state = doqa_pkg::S_DONE;
                end
            end
            doqa_pkg::S_EVICT:  n_state = doqa_pkg::S_CHECK;
            doqa_pkg::S_BYPASS: n_state = doqa_pkg::S_DONE;
            doqa_pkg::S_POP_RD: begin
                n_state = i_stat.empty ? doqa_pkg::S_DONE : doqa_pkg::S_POP;
            end
            doqa_pkg::S_POP:    n_state = doqa_pkg::S_DONE;
            doqa_pkg::S_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = doqa_pkg::S_IDLE;
                end
            end
            default:            n_state = doqa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            doqa_pkg::S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
            end
            doqa_pkg::S_CHECK: begin
                if (!i_stat.need_room) begin
                    o_ctrl.append = 1'b1;
                end else if (i_stat.empty) begin
                    o_ctrl.drop = 1'b1;
                end
            end
            doqa_pkg::S_EVICT: begin
                o_ctrl.unit_sub = 1'b1;
                o_ctrl.remove   = 1'b1;
                o_ctrl.drop     = 1'b1;
                o_ctrl.evict    = 1'b1;
            end
            doqa_pkg::S_BYPASS: begin
                if (i_stat.full) begin
                    o_ctrl.drop = 1'b1;
                end else begin
                    o_ctrl.append = 1'b1;
                end
            end
            doqa_pkg::S_POP_RD: begin
                o_ctrl = '0;
            end
            doqa_pkg::S_POP: begin
                o_ctrl.unit_sub = 1'b1;
                o_ctrl.remove   = 1'b1;
                o_ctrl.pop      = 1'b1;
            end
            doqa_pkg::S_DONE: begin
                o_ctrl.load_out = !i_stat.out_busy;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

// ----- design/drop_oldest_queue_admission_unit.sv -----
// Top level of the drop-oldest queue admission unit.
// A push goes from CHECK to DONE, with an EVICT and a fresh CHECK per evicted entry
// through the shared adder; a bypass push uses BYPASS, a pop POP_RD and POP (no POP on
// an empty queue). A new item is taken only back in IDLE; output stalls hold DONE.
// Synchronous active-low reset empties the queue, clears the drop counter and
// restores the message limit to 64 and the byte limit to 1048576; no clearing pass.
module drop_oldest_queue_admission_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [doqa_pkg::SIZE_W-1:0]         i_payload_size,
    input  logic                                i_bypass,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_accepted,
    output logic [doqa_pkg::MSG_W-1:0]          o_evicted,
    output logic                                o_pop_valid,
    output logic [doqa_pkg::SIZE_W-1:0]         o_pop_size,
    output logic [doqa_pkg::MSG_W-1:0]          o_entry_count,
    output logic [doqa_pkg::OUT_BYTE_W-1:0]     o_byte_total,
    output logic [doqa_pkg::SIZE_W-1:0]         o_dropped_total,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [doqa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [doqa_pkg::SIZE_W-1:0]         i_cfg_data
);

`include "drop_oldest_queue_admission_unit_assert.svh"

    doqa_pkg::t_stat w_stat;
    doqa_pkg::t_ctrl w_ctrl;

    logic [doqa_pkg::MSG_W-1:0]  r_msg_limit;
    logic [doqa_pkg::SIZE_W-1:0] r_byte_limit;

    logic [doqa_pkg::AW-1:0]     r_head;
    logic [doqa_pkg::CNT_W-1:0]  r_occ;
    logic [doqa_pkg::BYTE_W-1:0] r_bytes;
    logic [doqa_pkg::SIZE_W-1:0] r_drops;

    logic [doqa_pkg::SIZE_W-1:0] r_size;
    logic                        r_acc;
    logic [doqa_pkg::CNT_W-1:0]  r_evict;
    logic                        r_popv;
    logic [doqa_pkg::SIZE_W-1:0] r_pops;
    logic                        r_out_valid;

    logic                        w_in_accept;
    logic [doqa_pkg::SIZE_W-1:0] w_rdata;
    logic [doqa_pkg::SIZE_W-1:0] w_opnd;
    logic [doqa_pkg::BYTE_W-1:0] w_result;
    logic                        w_over;
    logic                        w_limit_hit;
    logic [doqa_pkg::TAIL_W-1:0] w_tail_sum;
    logic [doqa_pkg::TAIL_W-1:0] w_tail;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_ctrl.in_ready;
    assign w_in_accept = i_in_valid && w_ctrl.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_limit  <= doqa_pkg::MSG_LIMIT_RST;
            r_byte_limit <= doqa_pkg::BYTE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == doqa_pkg::CFG_MSG_LIMIT) begin
                r_msg_limit <= i_cfg_data[doqa_pkg::MSG_W-1:0];
            end else if (i_cfg_index == doqa_pkg::CFG_BYTE_LIMIT) begin
                r_byte_limit <= i_cfg_data;
            end
        end
    end

    // effective limit is min(message limit, DEPTH)
    assign w_limit_hit = ((doqa_pkg::CMP_W)'(r_occ) >= (doqa_pkg::CMP_W)'(r_msg_limit))
                      || (r_occ == doqa_pkg::FULL_COUNT);

    // op and bypass are only looked at in IDLE, straight from the input ports
    assign w_stat.op        = i_op;
    assign w_stat.bypass    = i_bypass;
    assign w_stat.need_room = w_limit_hit || w_over;
    assign w_stat.empty     = (r_occ == '0);
    assign w_stat.full      = (r_occ == doqa_pkg::FULL_COUNT);
    assign w_stat.out_busy  = r_out_valid && i_out_stall;

    doqa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    assign w_opnd = w_ctrl.unit_sub ? w_rdata : r_size;

    doqa_unit u_unit (
        .i_acc    (r_bytes),
        .i_opnd   (w_opnd),
        .i_sub    (w_ctrl.unit_sub),
        .i_limit  (r_byte_limit),
        .o_result (w_result),
        .o_over   (w_over)
    );

    assign w_tail_sum = (doqa_pkg::TAIL_W)'(r_head) + (doqa_pkg::TAIL_W)'(r_occ);
    assign w_tail     = (w_tail_sum >= doqa_pkg::DEPTH_TAIL)
                      ? (w_tail_sum - doqa_pkg::DEPTH_TAIL) : w_tail_sum;

    doqa_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_ctrl.append),
        .i_waddr (w_tail[doqa_pkg::AW-1:0]),
        .i_wdata (r_size),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_occ       <= '0;
            r_bytes     <= '0;
            r_drops     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctrl.append) begin
                r_occ   <= r_occ + (doqa_pkg::CNT_W)'(1);
                r_bytes <= w_result;
            end else if (w_ctrl.remove) begin
                r_head  <= (r_head == doqa_pkg::HEAD_LAST) ? '0
                         : r_head + (doqa_pkg::AW)'(1);
                r_occ   <= r_occ - (doqa_pkg::CNT_W)'(1);
                r_bytes <= w_result;
            end
            if (w_ctrl.drop && (r_drops != '1)) begin
                r_drops <= r_drops + (doqa_pkg::SIZE_W)'(1);
            end
            if (w_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_size  <= i_payload_size;
            r_acc   <= 1'b0;
            r_evict <= '0;
            r_popv  <= 1'b0;
            r_pops  <= '0;
        end else begin
            if (w_ctrl.append) begin
                r_acc <= 1'b1;
            end
            if (w_ctrl.evict) begin
                r_evict <= r_evict + (doqa_pkg::CNT_W)'(1);
            end
            if (w_ctrl.pop) begin
                r_popv <= 1'b1;
                r_pops <= w_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_out) begin
            o_accepted      <= r_acc;
            o_evicted       <= (doqa_pkg::MSG_W)'(r_evict);
            o_pop_valid     <= r_popv;
            o_pop_size      <= r_pops;
            o_entry_count   <= (doqa_pkg::MSG_W)'(r_occ);
            o_byte_total    <= (doqa_pkg::OUT_BYTE_W)'(r_bytes);
            o_dropped_total <= r_drops;
        end
    end

    assign o_out_valid = r_out_valid;

    `DOQA_CHECK(a_occ_bound, r_occ <= doqa_pkg::FULL_COUNT)
    `DOQA_CHECK(a_empty_no_bytes, (r_occ != '0) || (r_bytes == '0))
    `DOQA_CHECK_NEXT(a_busy_after_accept, w_in_accept, o_in_stall)
    `DOQA_CHECK(a_one_store_update, !(w_ctrl.append && w_ctrl.remove))

endmodule
